/* design/ledd_pkg.sv */
// Shared types, constants and arithmetic helpers for the luma error diffusion dither.
// Used by the controller, the datapath and the top level; no dependencies.

package ledd_pkg;

	// Image geometry and line store layout (three rows kept, row mod 3)
	localparam int IMAGE_SIZE = 512;
	localparam int COL_W      = $clog2(IMAGE_SIZE);
	localparam int LINE_DEPTH = 3 * IMAGE_SIZE;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);

	// Field widths
	localparam int ERR_W   = 7;
	localparam int SHARE_W = 5;
	localparam int LEVEL_W = 9;
	localparam int STEP_W  = 8;
	localparam int LNUM_W  = 18;

	localparam logic [STEP_W-1:0] STEP_RESET = 8'd64;
	localparam logic [STEP_W-1:0] STEP_MIN   = 8'd1;
	localparam logic [STEP_W-1:0] STEP_MAX   = 8'd128;

	// Luma weights; /1000 is done as >>3 then a reciprocal multiply for /125
	localparam logic [LNUM_W-1:0] LUMA_WR = 18'd299;
	localparam logic [LNUM_W-1:0] LUMA_WG = 18'd587;
	localparam logic [LNUM_W-1:0] LUMA_WB = 18'd114;
	localparam logic [15:0] LUMA_RECIP = 16'd33555;
	localparam int LUMA_SHIFT = 22;

	// Share /48 is done as >>4 then *43>>7 for /3
	localparam logic [11:0] SHARE_RECIP3 = 12'd43;

	// Kernel weights: current row (+1, +2) and the two rows below (-2..+2)
	localparam logic [2:0] JJN_CUR1 = 3'd7;
	localparam logic [2:0] JJN_CUR2 = 3'd5;
	localparam logic [2:0] JJN_ROW1 [5] = '{3'd3, 3'd5, 3'd7, 3'd5, 3'd3};
	localparam logic [2:0] JJN_ROW2 [5] = '{3'd1, 3'd3, 3'd5, 3'd3, 3'd1};

	// Line store selector
	typedef logic [1:0] store_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LUMA,
		ST_SUM,
		ST_DIV1,
		ST_DIV2,
		ST_DIV3,
		ST_DIST,
		ST_WR2,
		ST_FL0,
		ST_FL1,
		ST_FL2,
		ST_FL3,
		ST_FL4
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic luma_en;
		logic sum_en;
		logic div_en;
		logic dist_en;
		logic wr2_en;
		logic fl0;
		logic fl1;
		logic fl2;
		logic fl3;
		logic fl4;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_col;
		logic out_free;
	} stat_t;

	// Address of a column inside one of the three line stores
	function automatic logic [ADDR_W-1:0] line_addr(input store_t st,
			input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] off;
		case (st)
			2'd1:    off = ADDR_W'(IMAGE_SIZE);
			2'd2:    off = ADDR_W'(2 * IMAGE_SIZE);
			default: off = '0;
		endcase
		return off + ADDR_W'(col);
	endfunction

	// Saturating error add, clamps at the 7-bit ceiling
	function automatic logic [ERR_W-1:0] sat_add(input logic [ERR_W-1:0] a,
			input logic [ERR_W-1:0] b);
		logic [ERR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ERR_W] ? {ERR_W{1'b1}} : s[ERR_W-1:0];
	endfunction

	// (rem * w) / 48, truncated
	function automatic logic [SHARE_W-1:0] jjn_share(input logic [ERR_W-1:0] rem,
			input logic [2:0] w);
		logic [9:0]  prod;
		logic [5:0]  p16;
		logic [11:0] p3;
		prod = 10'(rem) * 10'(w);
		p16  = prod[9:4];
		p3   = 12'(p16) * SHARE_RECIP3;
		return p3[11:7];
	endfunction

endpackage

/* design/ledd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependency.

module ledd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/ledd_ctrl.sv */
// Sequencing state machine for the dither: one pixel at a time, plus a row-end flush.
// Depends on ledd_pkg for state_t, cmd_t and stat_t.

module ledd_ctrl import ledd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pixel_valid,
	output logic  pixel_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		pixel_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pixel_ready = 1'b1;
				if (pixel_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LUMA;
				end
			end
			ST_LUMA: begin
				cmd.luma_en = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_en = 1'b1;
				state_d    = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_en = 1'b1;
				state_d    = ST_DIV3;
			end
			ST_DIV3: begin
				cmd.div_en = 1'b1;
				state_d    = ST_DIST;
			end
			ST_DIST: begin
				// hold until the result register can take the beat
				if (stat.out_free) begin
					cmd.dist_en = 1'b1;
					state_d     = ST_WR2;
				end
			end
			ST_WR2: begin
				cmd.wr2_en = 1'b1;
				state_d    = stat.last_col ? ST_FL0 : ST_IDLE;
			end
			ST_FL0: begin
				cmd.fl0 = 1'b1;
				state_d = ST_FL1;
			end
			ST_FL1: begin
				cmd.fl1 = 1'b1;
				state_d = ST_FL2;
			end
			ST_FL2: begin
				cmd.fl2 = 1'b1;
				state_d = ST_FL3;
			end
			ST_FL3: begin
				cmd.fl3 = 1'b1;
				state_d = ST_FL4;
			end
			ST_FL4: begin
				cmd.fl4 = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/ledd_dpath.sv */
// Datapath of the dither: luma, carried error, remainder unit, error windows, line store.
// Depends on ledd_pkg and instantiates ledd_ram for the three error lines.

module ledd_dpath import ledd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               cfg_write,
	input  logic [STEP_W-1:0]  cfg_data,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [LEVEL_W-1:0] level,
	output logic               frame_end
);

	// Position and store rotation
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;
	store_t           st_cur_q;
	store_t           st_n1_q;
	store_t           st_n2_q;
	logic [STEP_W-1:0] quant_step_q;

	// Per-pixel working registers
	logic [LNUM_W-1:0]  luma_num_q;
	logic [7:0]         luma_q;
	logic [ERR_W-1:0]   err_cur_q;
	logic [LEVEL_W-1:0] value_q;
	logic [LEVEL_W-1:0] dshift_q;
	logic [STEP_W-1:0]  rem_q;
	logic [STEP_W-1:0]  step_q;

	// Error windows: current row (next two columns), rows below (five columns)
	logic [5:0]       cur0_q;
	logic [5:0]       cur1_q;
	logic [ERR_W-1:0] n_q [5];
	logic [ERR_W-1:0] m_q [5];
	logic [ERR_W-1:0] m_out_q;

	// Result register
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic               frame_end_q;

	// Line store port
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ERR_W-1:0]  ram_wdata;
	logic [ERR_W-1:0]  ram_rdata;

	// Combinational helpers
	logic               last_col;
	logic               last_row;
	logic               first_row;
	logic               col_ge2;
	logic               col_p2_ok;
	logic [COL_W-1:0]   col_m2;
	logic [COL_W-1:0]   col_p2;
	logic [LNUM_W-1:0]  luma_num;
	logic [30:0]        luma_prod;
	logic [ERR_W-1:0]   err_sum;
	logic [STEP_W-1:0]  step_clamp;
	logic [STEP_W-1:0]  div_r;
	logic [ERR_W-1:0]   rem7;
	logic [LEVEL_W-1:0] base;
	logic [SHARE_W-1:0] s_cur1;
	logic [SHARE_W-1:0] s_cur2;
	logic [ERR_W-1:0]   n_add [5];
	logic [ERR_W-1:0]   m_add [5];
	logic [ERR_W-1:0]   rd_masked;

	assign last_col  = col_q == COL_W'(IMAGE_SIZE - 1);
	assign last_row  = row_q == COL_W'(IMAGE_SIZE - 1);
	assign first_row = row_q == '0;
	assign col_ge2   = col_q >= COL_W'(2);
	assign col_p2_ok = ({1'b0, col_q} + (COL_W + 1)'(2)) < (COL_W + 1)'(IMAGE_SIZE);
	assign col_m2    = col_q - COL_W'(2);
	assign col_p2    = col_q + COL_W'(2);

	assign stat.last_col = last_col;
	assign stat.out_free = !out_valid_q || result_ready;

	// Luma numerator and divide by 1000
	assign luma_num  = LNUM_W'(red) * LUMA_WR + LNUM_W'(green) * LUMA_WG
			+ LNUM_W'(blue) * LUMA_WB;
	assign luma_prod = 31'(luma_num_q[LNUM_W-1:3]) * 31'(LUMA_RECIP);

	// Carried error plus same-row shares
	assign err_sum = sat_add(err_cur_q, ERR_W'(cur0_q));

	// Clamp the configured step into 1..128
	always_comb begin
		if (quant_step_q < STEP_MIN) begin
			step_clamp = STEP_MIN;
		end else if (quant_step_q > STEP_MAX) begin
			step_clamp = STEP_MAX;
		end else begin
			step_clamp = quant_step_q;
		end
	end

	// Remainder unit: three restoring steps per cycle, MSB first
	always_comb begin
		div_r = rem_q;
		for (int i = 0; i < 3; i++) begin
			div_r = {div_r[STEP_W-2:0], dshift_q[LEVEL_W-1-i]};
			if (div_r >= step_q) begin
				div_r = div_r - step_q;
			end
		end
	end

	// Shares of the remainder
	assign rem7   = rem_q[ERR_W-1:0];
	assign base   = value_q - LEVEL_W'(rem7);
	assign s_cur1 = jjn_share(rem7, JJN_CUR1);
	assign s_cur2 = jjn_share(rem7, JJN_CUR2);

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			n_add[k] = sat_add(n_q[k], ERR_W'(jjn_share(rem7, JJN_ROW1[k])));
			m_add[k] = sat_add(m_q[k], ERR_W'(jjn_share(rem7, JJN_ROW2[k])));
		end
	end

	// First row of a frame sees no carried error
	assign rd_masked = first_row ? '0 : ram_rdata;

	// Line store port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = line_addr(st_n1_q, col_m2);
		ram_raddr = line_addr(st_cur_q, col_q);
		ram_wdata = n_add[0];
		if (cmd.accept) begin
			ram_re = 1'b1;
		end
		if (cmd.luma_en) begin
			ram_re    = col_p2_ok;
			ram_raddr = line_addr(st_n1_q, col_p2);
		end
		if (cmd.dist_en) begin
			ram_we = col_ge2;
		end
		if (cmd.wr2_en) begin
			ram_we    = col_ge2;
			ram_waddr = line_addr(st_n2_q, col_m2);
			ram_wdata = m_out_q;
		end
		if (cmd.fl0) begin
			ram_we    = 1'b1;
			ram_waddr = line_addr(st_n2_q, COL_W'(IMAGE_SIZE - 2));
			ram_wdata = m_q[0];
		end
		if (cmd.fl1) begin
			ram_we    = 1'b1;
			ram_waddr = line_addr(st_n2_q, COL_W'(IMAGE_SIZE - 1));
			ram_wdata = m_q[1];
		end
		if (cmd.fl2) begin
			ram_we    = 1'b1;
			ram_waddr = line_addr(st_n1_q, COL_W'(IMAGE_SIZE - 2));
			ram_wdata = n_q[0];
			ram_re    = 1'b1;
			ram_raddr = line_addr(st_n2_q, COL_W'(0));
		end
		if (cmd.fl3) begin
			ram_we    = 1'b1;
			ram_waddr = line_addr(st_n1_q, COL_W'(IMAGE_SIZE - 1));
			ram_wdata = n_q[1];
			ram_re    = 1'b1;
			ram_raddr = line_addr(st_n2_q, COL_W'(1));
		end
	end

	ledd_ram #(
		.WIDTH(ERR_W),
		.DEPTH(LINE_DEPTH)
	) u_lines (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state: position, stores, step, error windows, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			st_cur_q     <= 2'd0;
			st_n1_q      <= 2'd1;
			st_n2_q      <= 2'd2;
			quant_step_q <= STEP_RESET;
			cur0_q       <= '0;
			cur1_q       <= '0;
			for (int k = 0; k < 5; k++) begin
				n_q[k] <= '0;
				m_q[k] <= '0;
			end
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				quant_step_q <= cfg_data;
			end

			// drop the beat once taken, reload on a new result
			if (cmd.dist_en) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			// pick up the carried error of the column two ahead on the next row
			if (cmd.sum_en) begin
				n_q[4] <= rd_masked;
			end

			// add shares and advance the windows by one column
			if (cmd.dist_en) begin
				cur0_q <= cur1_q + 6'(s_cur1);
				cur1_q <= 6'(s_cur2);
				for (int k = 0; k < 4; k++) begin
					n_q[k] <= n_add[k+1];
					m_q[k] <= m_add[k+1];
				end
				n_q[4] <= '0;
				m_q[4] <= '0;
			end

			if (cmd.wr2_en && !last_col) begin
				col_q <= col_q + COL_W'(1);
			end

			// prefetch the first two columns of the new next row
			if (cmd.fl3) begin
				n_q[2] <= last_row ? '0 : ram_rdata;
			end

			// start a new row, or a new frame after the last row
			if (cmd.fl4) begin
				n_q[0] <= '0;
				n_q[1] <= '0;
				n_q[3] <= last_row ? '0 : ram_rdata;
				n_q[4] <= '0;
				for (int k = 0; k < 5; k++) begin
					m_q[k] <= '0;
				end
				cur0_q <= '0;
				cur1_q <= '0;
				col_q  <= '0;
				if (last_row) begin
					row_q    <= '0;
					st_cur_q <= 2'd0;
					st_n1_q  <= 2'd1;
					st_n2_q  <= 2'd2;
				end else begin
					row_q    <= row_q + COL_W'(1);
					st_cur_q <= st_n1_q;
					st_n1_q  <= st_n2_q;
					st_n2_q  <= st_cur_q;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			luma_num_q <= luma_num;
		end
		if (cmd.luma_en) begin
			luma_q    <= luma_prod[LUMA_SHIFT +: 8];
			err_cur_q <= rd_masked;
		end
		if (cmd.sum_en) begin
			value_q  <= LEVEL_W'(luma_q) + LEVEL_W'(err_sum);
			dshift_q <= LEVEL_W'(luma_q) + LEVEL_W'(err_sum);
			rem_q    <= '0;
			step_q   <= step_clamp;
		end
		if (cmd.div_en) begin
			rem_q    <= div_r;
			dshift_q <= {dshift_q[LEVEL_W-4:0], 3'b000};
		end
		if (cmd.dist_en) begin
			m_out_q     <= m_add[0];
			level_q     <= base;
			frame_end_q <= last_row && last_col;
		end
	end

	assign result_valid = out_valid_q;
	assign level        = level_q;
	assign frame_end    = frame_end_q;

	// Remainder must be below the step when it is spread
	a_rem_below_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dist_en |-> (rem_q < step_q))
		else $error("remainder not below quantization step");

	// Sum of luma and carried error stays within the level range
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dist_en |-> (value_q <= LEVEL_W'(382)))
		else $error("pixel value out of range");

	// A waiting result beat is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dist_en |-> (!out_valid_q || result_ready))
		else $error("result register overwritten while stalled");

	// Writes never touch the row being consumed
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr < line_addr(st_cur_q, '0)
			|| ram_waddr > line_addr(st_cur_q, COL_W'(IMAGE_SIZE - 1))))
		else $error("write into current row store");

	// The three store selectors stay distinct
	a_store_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(st_cur_q != st_n1_q) && (st_n1_q != st_n2_q) && (st_cur_q != st_n2_q))
		else $error("line store rotation broken");

endmodule

/* design/luma_error_diffusion_dither.sv */
// Top level of the luma error diffusion dither: controller plus datapath.
// Depends on ledd_pkg, ledd_ctrl and ledd_dpath.
//
//   channel   signals                                   direction  handshake
//   pixel     red, green, blue                          in         pixel_valid / pixel_ready
//   result    level, frame_end                          out        result_valid / result_ready
//   config    cfg_data (quant_step)                     in         cfg_write, no wait
//
// A pixel steps through the accept state, luma, carried error, the remainder unit (three
// bits a cycle) and two line store write slots before the next pixel can be accepted.
// The last pixel of each row adds flush states that write the last two columns of error
// into the line store (single write port) and prefetch the next row's first two.
// No clearing pass after reset: the first row of every frame reads its carried error
// as zero and the rows below are fully rewritten before they are read.
// The result register holds one beat; the next pixel is accepted while it waits, and
// only the distribution step stalls when the previous beat has not been taken.

module luma_error_diffusion_dither import ledd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [STEP_W-1:0]  cfg_data,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [LEVEL_W-1:0] level,
	output logic               frame_end
);

	cmd_t  cmd;
	stat_t stat;

	ledd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	ledd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.level       (level),
		.frame_end   (frame_end)
	);

endmodule

/* bench/luma_error_diffusion_dither_tb.sv */
// Self-checking bench for luma_error_diffusion_dither: a scoreboard class predicts each
// quantized level and frame_end flag, and plain tasks drive pixels and the step register.
// Depends on ledd_pkg and the luma_error_diffusion_dither top level.
`timescale 1ns / 1ps

module luma_error_diffusion_dither_tb import ledd_pkg::*; ();

	localparam int STALL_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 24;
	localparam int PHASES       = 10;
	localparam int PHASE_PIXELS = 190;
	localparam int ERR_MAX      = 2 ** ERR_W - 1;
	localparam int SHARE_DIV    = 48;

	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic               frame_end;
	} dither_beat_t;

	// Predict the dither output and compare it with every result beat
	class dither_tracker;
		bit [ERR_W-1:0] carried [LINE_DEPTH];
		int             col;
		int             row;
		int unsigned    step = STEP_RESET;
		int unsigned    kernel [3][5] = '{'{0, 0, 0, 7, 5}, '{3, 5, 7, 5, 3}, '{1, 3, 5, 3, 1}};
		dither_beat_t   levels_due [$];
		int             mismatches;

		function void set_step(input logic [STEP_W-1:0] value);
			step = value;
		endfunction

		function void note_pixel(input logic [7:0] r, input logic [7:0] g,
				input logic [7:0] b);
			int unsigned luma, total, base, rem, q, sum;
			int slot, tr, tc;
			dither_beat_t beat;
			// clamp the step into 1..128
			q = step;
			if (q < STEP_MIN)
				q = STEP_MIN;
			if (q > STEP_MAX)
				q = STEP_MAX;
			luma = (299 * int'(r) + 587 * int'(g) + 114 * int'(b)) / 1000;
			slot = (row % 3) * IMAGE_SIZE + col;
			total = luma + carried[slot];
			carried[slot] = '0;
			base = (total / q) * q;
			rem = total - base;
			// spread the remainder; drop shares outside the image
			for (int dr = 0; dr < 3; dr++) begin
				for (int dc = -2; dc <= 2; dc++) begin
					tr = row + dr;
					tc = col + dc;
					if (kernel[dr][dc + 2] == 0 || tr >= IMAGE_SIZE || tc < 0 ||
							tc >= IMAGE_SIZE)
						continue;
					slot = (tr % 3) * IMAGE_SIZE + tc;
					sum = carried[slot] + rem * kernel[dr][dc + 2] / SHARE_DIV;
					carried[slot] = ERR_W'((sum > ERR_MAX) ? ERR_MAX : sum);
				end
			end
			beat.level = LEVEL_W'(base);
			beat.frame_end = (row == IMAGE_SIZE - 1 && col == IMAGE_SIZE - 1);
			levels_due.push_back(beat);
			// advance the raster position, wrap at frame end
			col++;
			if (col >= IMAGE_SIZE) begin
				col = 0;
				row++;
				if (row >= IMAGE_SIZE)
					row = 0;
			end
		endfunction

		function void check_result(input logic [LEVEL_W-1:0] level, input logic frame_end);
			dither_beat_t want;
			if (levels_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with no pixel pending: level %0d frame_end %0b",
					$time, level, frame_end);
				return;
			end
			want = levels_due.pop_front();
			if (level !== want.level) begin
				mismatches++;
				$display("%0t: level expected %0d actual %0d", $time, want.level, level);
			end
			if (frame_end !== want.frame_end) begin
				mismatches++;
				$display("%0t: frame_end expected %0b actual %0b", $time,
					want.frame_end, frame_end);
			end
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_write    = 1'b0;
	logic [STEP_W-1:0]  cfg_data     = '0;
	logic               pixel_valid  = 1'b0;
	logic               pixel_ready;
	logic [7:0]         red          = '0;
	logic [7:0]         green        = '0;
	logic [7:0]         blue         = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [LEVEL_W-1:0] level;
	logic               frame_end;

	dither_tracker tracker = new();
	bit            steady_run;
	int            quiet_cycles;

	luma_error_diffusion_dither u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.level        (level),
		.frame_end    (frame_end)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (steady_run)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Present one pixel beat and hold it until accepted
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do
			@(posedge clk);
		while (!pixel_ready);
		tracker.note_pixel(r, g, b);
	endtask

	// Drop valid, let every pending result drain
	task automatic drain_results();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (tracker.levels_due.size() != 0)
			@(negedge clk);
	endtask

	// Write the step register once every pending result has drained
	task automatic write_step(input logic [STEP_W-1:0] value);
		drain_results();
		cfg_data <= value;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
		tracker.set_step(value);
	endtask

	task automatic send_random_pixel();
		logic [7:0] grey;
		int mode;
		mode = $urandom_range(0, 9);
		grey = 8'($urandom);
		if (mode == 0)
			send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
				$urandom_range(0, 1) ? 8'hFF : 8'h00);
		else if (mode <= 3)
			// flat areas make the carried error build up
			send_pixel(grey, grey + 8'($urandom_range(0, 2)), grey);
		else
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Result side: random stalls with runs of steady ready
	initial begin : result_sink
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (steady_run)
				result_ready <= 1'b1;
			else if (result_ready) begin
				hold = pick_gap();
				if (hold > 0) begin
					result_ready <= 1'b0;
					hold--;
				end else
					hold = $urandom_range(0, 6);
			end else begin
				result_ready <= 1'b1;
				hold = $urandom_range(0, 6);
			end
		end
	end

	// Check each accepted result beat
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_result(level, frame_end);
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [STEP_W-1:0] step_plan [PHASES];
		step_plan = '{8'd1, 8'd128, 8'd129, 8'd3, 8'd0, 8'd100, 8'd64, 8'd37, 8'd200, 8'd16};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: component extremes at the reset step
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'h55, 8'hAA, 8'h55);
		send_pixel(8'hAA, 8'h55, 8'hAA);
		send_pixel(8'h01, 8'h01, 8'h01);
		send_pixel(8'hFE, 8'hFE, 8'hFE);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h7F, 8'h7F, 8'h7F);
		send_pixel(8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'hFF);
		send_pixel(8'h3F, 8'hC0, 8'h21);

		// Directed: a zero step acts as one
		write_step(8'd0);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h12, 8'h34, 8'h56);
		send_pixel(8'h80, 8'h40, 8'h20);
		send_pixel(8'h01, 8'h02, 8'h03);

		// Directed: a step above range acts as 128
		write_step(8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h7F, 8'h7F, 8'h7F);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hC8, 8'h64, 8'h32);

		// Random phases, one step setting each, running past the third row
		for (int p = 0; p < PHASES; p++) begin
			write_step(p >= 7 ? STEP_W'($urandom_range(0, 255)) : step_plan[p]);
			steady_run = ($urandom_range(0, 4) == 0);
			for (int n = 0; n < PHASE_PIXELS; n++)
				send_random_pixel();
		end
		steady_run = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
design/ledd_pkg.sv
design/ledd_ram.sv
design/ledd_ctrl.sv
design/ledd_dpath.sv
design/luma_error_diffusion_dither.sv
bench/luma_error_diffusion_dither_tb.sv
